### rtl/core/tsf_pkg.sv
`default_nettype none

package tsf_pkg;

	// Field widths of the channels and the configuration register.
	localparam int unsigned ByteW   = 8;
	localparam int unsigned LenW    = 11;
	localparam int unsigned LimitW  = 10;
	localparam int unsigned TotalW  = 16;

	// Limit that applies after reset.
	localparam logic [LimitW-1:0] LimitReset = 10'd256;

	// Characters with a meaning of their own.
	localparam logic [ByteW-1:0] CH_NUL    = 8'h00;
	localparam logic [ByteW-1:0] CH_BS     = 8'h08;
	localparam logic [ByteW-1:0] CH_TAB    = 8'h09;
	localparam logic [ByteW-1:0] CH_LF     = 8'h0A;
	localparam logic [ByteW-1:0] CH_FF     = 8'h0C;
	localparam logic [ByteW-1:0] CH_CR     = 8'h0D;
	localparam logic [ByteW-1:0] CH_QUOTE  = 8'h22;
	localparam logic [ByteW-1:0] CH_COMMA  = 8'h2C;
	localparam logic [ByteW-1:0] CH_SLASH  = 8'h2F;
	localparam logic [ByteW-1:0] CH_LT     = 8'h3C;
	localparam logic [ByteW-1:0] CH_GT     = 8'h3E;
	localparam logic [ByteW-1:0] CH_BSLASH = 8'h5C;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_CHAR  = 2'd0,
		KIND_EOL   = 2'd1,
		KIND_TRUNC = 2'd2
	} kind_t;

	// One result item as held in the output queue.
	typedef struct packed {
		kind_t             kind;
		logic [ByteW-1:0]  out_char;
		logic [LenW-1:0]   line_length;
		logic [TotalW-1:0] truncation_total;
		logic              last;
	} result_t;

endpackage

`default_nettype wire

### rtl/core/tsf_if.sv
`default_nettype none

// Input channel: one received character per transfer.
interface tsf_in_if import tsf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ByteW-1:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

// Output channel: one result item per transfer.
interface tsf_out_if import tsf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        kind;
	logic [ByteW-1:0]  out_char;
	logic [LenW-1:0]   line_length;
	logic [TotalW-1:0] truncation_total;
	logic              last;

	modport source (output valid, output kind, output out_char, output line_length,
		output truncation_total, output last, input ready);
	modport sink   (input valid, input kind, input out_char, input line_length,
		input truncation_total, input last, output ready);
endinterface

`default_nettype wire

### rtl/core/tag_strip_escape_line_filter_core.sv
// Line filter for tag-marked meter text.
// in_item carries one received byte per transfer; out_item carries result
// items: a character, an end of line with the cleaned line length, or a line
// truncation. The flag last marks the final result caused by one byte; a byte
// that is dropped causes no result at all. cfg_wr_en/cfg_wr_data write the
// line length limit; write it only while the block is idle.
// A byte taken from in_item is held in the decode stage and decoded there; its
// results are written into the output queue when that stage advances, and the
// head of the queue is offered on out_item.
// Throughput: one byte per cycle while each byte gives at most one result and
// the receiver keeps up; an escaped character gives two results and the single
// output port moves one per cycle, so such bytes fill the queue. The decode
// stage waits whenever the four-entry output queue has fewer than two free slots.
// Reset clears the tag and line state, the truncation count and the queue,
// and sets the limit to 256. When the receiver stalls, results wait in the
// queue and in_item.ready drops while the decode stage holds a byte and the
// queue holds three or more results; nothing is lost or repeated.
`default_nettype none

module tag_strip_escape_line_filter_core import tsf_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	tsf_in_if.sink                 in_item,
	tsf_out_if.source              out_item,
	input  wire logic              cfg_wr_en,
	input  wire logic [LimitW-1:0] cfg_wr_data
);

	localparam int unsigned QDepth = 4;
	localparam int unsigned CntW   = $clog2(QDepth + 1);

	// Configuration register.
	logic [LimitW-1:0] max_len_q;

	// Decode stage.
	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;
	logic             adv;

	// Line state.
	logic              in_tag_q, in_tag_d;
	logic [LenW-1:0]   raw_q, raw_d;
	logic [LenW-1:0]   emit_q, emit_d;
	logic              comma_q, comma_d;
	logic [TotalW-1:0] trunc_q, trunc_d;

	// Decode results.
	logic [1:0] n_res;
	result_t    r0, r1;
	logic       esc;

	// Output queue, head at entry 0.
	result_t         queue_q [QDepth];
	logic [CntW-1:0] cnt_q;
	logic [CntW-1:0] cnt_pop;
	logic            pop;

	// Limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= LimitReset;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	// The decode stage moves on when the queue can take two results.
	assign adv           = valid_s1 && (cnt_q <= CntW'(QDepth - 2));
	assign in_item.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_item.ready) begin
			valid_s1 <= in_item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_item.ready && in_item.valid) begin
			byte_s1 <= in_item.in_byte;
		end
	end

	// Decode one byte against the line state.
	always_comb begin
		n_res    = 2'd0;
		r0       = '0;
		r1       = '0;
		esc      = 1'b0;
		in_tag_d = in_tag_q;
		raw_d    = raw_q;
		emit_d   = emit_q;
		comma_d  = comma_q;
		trunc_d  = trunc_q;

		if (raw_q >= {1'b0, max_len_q}) begin
			// Line too long: the byte is lost and a new line begins.
			if (trunc_q != '1) begin
				trunc_d = trunc_q + TotalW'(1);
			end
			n_res   = 2'd1;
			r0.kind = KIND_TRUNC;
			raw_d   = '0;
			emit_d  = '0;
			comma_d = 1'b0;
		end else if (byte_s1 inside {CH_NUL, CH_TAB, CH_FF, CH_BS, CH_LF}) begin
			n_res = 2'd0;
		end else begin
			case (byte_s1)
				CH_CR: begin
					n_res          = 2'd1;
					r0.kind        = KIND_EOL;
					r0.line_length = emit_q;
					raw_d          = '0;
					emit_d         = '0;
					comma_d        = 1'b0;
				end
				CH_QUOTE, CH_BSLASH: begin
					esc = 1'b1;
				end
				CH_SLASH: begin
					esc = !in_tag_q;
				end
				CH_LT: begin
					in_tag_d = 1'b1;
					raw_d    = raw_q + LenW'(1);
					if (!comma_q) begin
						n_res       = 2'd1;
						r0.kind     = KIND_CHAR;
						r0.out_char = CH_COMMA;
						emit_d      = emit_q + LenW'(1);
						comma_d     = 1'b1;
					end
				end
				CH_GT: begin
					in_tag_d = 1'b0;
				end
				default: begin
					if (!in_tag_q) begin
						n_res       = 2'd1;
						r0.kind     = KIND_CHAR;
						r0.out_char = byte_s1;
						emit_d      = emit_q + LenW'(1);
						raw_d       = raw_q + LenW'(1);
						comma_d     = (byte_s1 == CH_COMMA);
					end
				end
			endcase
		end

		// Escaped character: a backslash, then the character itself.
		if (esc) begin
			n_res       = 2'd2;
			r0.kind     = KIND_CHAR;
			r0.out_char = CH_BSLASH;
			r1.kind     = KIND_CHAR;
			r1.out_char = byte_s1;
			emit_d      = emit_q + LenW'(2);
			raw_d       = raw_q + LenW'(2);
			comma_d     = 1'b0;
		end

		r0.truncation_total = trunc_d;
		r1.truncation_total = trunc_d;
		r0.last             = (n_res == 2'd1);
		r1.last             = 1'b1;
	end

	// Line state advances with each decoded byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_tag_q <= 1'b0;
			raw_q    <= '0;
			emit_q   <= '0;
			comma_q  <= 1'b0;
			trunc_q  <= '0;
		end else if (adv) begin
			in_tag_q <= in_tag_d;
			raw_q    <= raw_d;
			emit_q   <= emit_d;
			comma_q  <= comma_d;
			trunc_q  <= trunc_d;
		end
	end

	// Output queue: the head leaves on a transfer, new results go behind the rest.
	assign pop     = out_item.valid && out_item.ready;
	assign cnt_pop = cnt_q - CntW'(pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_pop + (adv ? CntW'(n_res) : CntW'(0));
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QDepth; i++) begin
			if (adv && (n_res != 2'd0) && (CntW'(i) == cnt_pop)) begin
				queue_q[i] <= r0;
			end else if (adv && (n_res == 2'd2) && (CntW'(i) == cnt_pop + CntW'(1))) begin
				queue_q[i] <= r1;
			end else if (pop && (i < QDepth - 1)) begin
				queue_q[i] <= queue_q[(i < QDepth - 1) ? i + 1 : i];
			end
		end
	end

	// Head of the queue drives the output channel.
	assign out_item.valid            = (cnt_q != '0);
	assign out_item.kind             = queue_q[0].kind;
	assign out_item.out_char         = queue_q[0].out_char;
	assign out_item.line_length      = queue_q[0].line_length;
	assign out_item.truncation_total = queue_q[0].truncation_total;
	assign out_item.last             = queue_q[0].last;

endmodule

`default_nettype wire

### test/tb.sv
`timescale 1ns / 1ps

module tb;
	import tsf_pkg::*;

	localparam int CycleLimit   = 200000;
	localparam int SettleCycles = 8;
	localparam int PhaseItems   = 70;
	localparam int BurstRounds  = 20;

	// Tracks the cleaned stream: line and tag state plus the results still owed.
	class clean_stream_tracker;
		logic [LimitW-1:0] limit;
		logic              in_tag;
		logic              last_comma;
		logic [LenW-1:0]   raw_len;
		logic [LenW-1:0]   emit_len;
		logic [TotalW-1:0] trunc_cnt;
		result_t           owed_results[$];
		int                errors;

		function new();
			limit = LimitReset;
			in_tag = 1'b0;
			trunc_cnt = '0;
			errors = 0;
			new_line();
		endfunction

		function void new_line();
			raw_len = '0;
			emit_len = '0;
			last_comma = 1'b0;
		endfunction

		function void set_limit(logic [LimitW-1:0] v);
			limit = v;
		endfunction

		function int pending();
			return owed_results.size();
		endfunction

		function void owe(kind_t k, logic [ByteW-1:0] ch, logic [LenW-1:0] len);
			result_t r;
			r.kind = k;
			r.out_char = ch;
			r.line_length = len;
			r.truncation_total = trunc_cnt;
			r.last = 1'b0;
			owed_results.insert(owed_results.size(), r);
		endfunction

		function void owe_char(logic [ByteW-1:0] ch);
			owe(KIND_CHAR, ch, '0);
			emit_len = emit_len + 1'b1;
			last_comma = (ch == CH_COMMA);
		endfunction

		// Called for every accepted input transfer.
		function void take_byte(logic [ByteW-1:0] b);
			int first;
			first = owed_results.size();
			// The length check comes before decoding, even for a null byte.
			if (raw_len >= {1'b0, limit}) begin
				if (trunc_cnt != '1)
					trunc_cnt = trunc_cnt + 1'b1;
				owe(KIND_TRUNC, '0, '0);
				new_line();
			end else begin
				case (b)
					CH_NUL, CH_TAB, CH_FF, CH_BS, CH_LF: ;
					CH_CR: begin
						owe(KIND_EOL, '0, emit_len);
						new_line();
					end
					CH_QUOTE, CH_BSLASH: begin
						owe_char(CH_BSLASH);
						owe_char(b);
						raw_len = raw_len + 2'd2;
					end
					CH_SLASH: begin
						if (!in_tag) begin
							owe_char(CH_BSLASH);
							owe_char(b);
							raw_len = raw_len + 2'd2;
						end
					end
					CH_LT: begin
						in_tag = 1'b1;
						raw_len = raw_len + 1'b1;
						// A tag right after an emitted comma adds no second comma.
						if (!last_comma)
							owe_char(CH_COMMA);
					end
					CH_GT: in_tag = 1'b0;
					default: begin
						if (!in_tag) begin
							owe_char(b);
							raw_len = raw_len + 1'b1;
						end
					end
				endcase
			end
			if (owed_results.size() > first)
				owed_results[owed_results.size() - 1].last = 1'b1;
		endfunction

		// Called for every accepted output transfer.
		function void check_result(result_t got);
			result_t want;
			if (owed_results.size() == 0) begin
				$error("unexpected result: kind %0d char %0h length %0d total %0d last %0b",
					got.kind, got.out_char, got.line_length, got.truncation_total, got.last);
				errors++;
				return;
			end
			want = owed_results.pop_front();
			if (got.kind !== want.kind) begin
				$error("kind: expected %0d, got %0d", want.kind, got.kind);
				errors++;
			end
			if (got.out_char !== want.out_char) begin
				$error("out_char: expected %0h, got %0h", want.out_char, got.out_char);
				errors++;
			end
			if (got.line_length !== want.line_length) begin
				$error("line_length: expected %0d, got %0d", want.line_length, got.line_length);
				errors++;
			end
			if (got.truncation_total !== want.truncation_total) begin
				$error("truncation_total: expected %0d, got %0d",
					want.truncation_total, got.truncation_total);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0b, got %0b", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [LimitW-1:0] cfg_wr_data;
	logic tx_steady;
	logic rx_steady;
	int cycles;
	int fed;

	tsf_in_if in_ch();
	tsf_out_if out_ch();

	clean_stream_tracker tracker;

	tag_strip_escape_line_filter_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_item     (in_ch),
		.out_item    (out_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always #2 clk = ~clk;

	// Mostly short idle stretches, now and then a long one.
	function automatic int idle_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Receiver side: random stalls unless held steady.
	initial begin
		int hold;
		hold = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_steady || hold == 0) begin
				out_ch.ready <= 1'b1;
				if (!rx_steady && $urandom_range(0, 3) == 0)
					hold = idle_len();
			end else begin
				out_ch.ready <= 1'b0;
				hold--;
			end
		end
	end

	// Both channels are observed at the same edge the transfer happens.
	always @(posedge clk) begin
		result_t got;
		if (arst_n) begin
			if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
				tracker.take_byte(in_ch.in_byte);
			if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
				got.kind = kind_t'(out_ch.kind);
				got.out_char = out_ch.out_char;
				got.line_length = out_ch.line_length;
				got.truncation_total = out_ch.truncation_total;
				got.last = out_ch.last;
				tracker.check_result(got);
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("tag_strip_escape_line_filter_core regression: fail");
			$finish;
		end
	end

	// Offers one byte and waits for its transfer; valid stays up if no gap follows.
	task automatic send_byte(input logic [ByteW-1:0] b);
		int gap;
		in_ch.valid <= 1'b1;
		in_ch.in_byte <= b;
		do
			@(posedge clk);
		while (in_ch.ready !== 1'b1);
		if (tx_steady || $urandom_range(0, 1) == 0)
			gap = 0;
		else
			gap = idle_len();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Counts only bytes that the filter does something with.
	task automatic feed(input logic [ByteW-1:0] b);
		send_byte(b);
		if (!(b inside {CH_NUL, CH_TAB, CH_FF, CH_BS, CH_LF}))
			fed++;
	endtask

	task automatic idle_input();
		in_ch.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic set_limit(input logic [LimitW-1:0] v);
		idle_input();
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tracker.set_limit(v);
	endtask

	// Meter text is mostly printable with tags, escapes and commas mixed in.
	function automatic logic [ByteW-1:0] meter_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return ByteW'($urandom_range(8'h20, 8'h7E));
		if (r < 50) return CH_LT;
		if (r < 60) return CH_GT;
		if (r < 66) return CH_QUOTE;
		if (r < 72) return CH_BSLASH;
		if (r < 78) return CH_SLASH;
		if (r < 84) return CH_COMMA;
		if (r < 90) begin
			case ($urandom_range(0, 4))
				0: return CH_NUL;
				1: return CH_TAB;
				2: return CH_FF;
				3: return CH_BS;
				default: return CH_LF;
			endcase
		end
		return ByteW'($urandom_range(0, 255));
	endfunction

	// One line of random text, usually closed by a carriage return.
	task automatic send_line(input int lim);
		int n;
		if ($urandom_range(0, 9) == 0)
			n = $urandom_range(0, (lim + 4 < 60) ? lim + 4 : 60);
		else
			n = $urandom_range(0, 12);
		for (int k = 0; k < n; k++)
			feed(meter_byte());
		if ($urandom_range(0, 9) != 0)
			feed(CH_CR);
		// Now and then hold off until the output has caught up.
		if ($urandom_range(0, 40) == 0) begin
			idle_input();
			wait_drained();
		end
	endtask

	task automatic random_phase(input logic [LimitW-1:0] lim);
		int start;
		set_limit(lim);
		start = fed;
		while (fed - start < PhaseItems)
			send_line(lim);
		idle_input();
	endtask

	initial begin
		logic [ByteW-1:0] opening_bytes[$];
		logic [ByteW-1:0] short_limit_bytes[$];

		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_ch.valid = 1'b0;
		in_ch.in_byte = '0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		cycles = 0;
		fed = 0;
		tracker = new();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed bytes under the reset limit: drops, escapes, tags and a tag after a comma.
		opening_bytes = '{8'h61, CH_NUL, CH_TAB, CH_FF, CH_BS, CH_LF, CH_QUOTE, CH_BSLASH,
			CH_SLASH, CH_COMMA, CH_LT, 8'h78, CH_SLASH, CH_QUOTE, CH_BSLASH, CH_GT,
			CH_LT, CH_GT, 8'hFF, 8'h80, CH_CR, CH_CR};
		foreach (opening_bytes[k])
			send_byte(opening_bytes[k]);

		// Limit of one: a null byte still truncates, the tag survives a truncation.
		set_limit(10'd1);
		short_limit_bytes = '{8'h61, CH_NUL, CH_LT, 8'h71, 8'h71, CH_GT, CH_QUOTE, 8'h61};
		foreach (short_limit_bytes[k])
			send_byte(short_limit_bytes[k]);

		random_phase(10'd1023);
		random_phase(10'd1);
		random_phase(10'd5);
		random_phase(LimitW'($urandom_range(2, 40)));

		// A burst of truncations with both sides at full rate.
		set_limit(10'd1);
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		for (int k = 0; k < BurstRounds; k++) begin
			send_byte(8'h61);
			send_byte(8'h62);
		end
		idle_input();
		wait_drained();
		tx_steady = 1'b0;
		rx_steady = 1'b0;

		random_phase(LimitW'($urandom_range(1, 1023)));
		random_phase(LimitW'($urandom_range(2, 24)));

		idle_input();
		wait_drained();
		if (tracker.errors == 0)
			$display("tag_strip_escape_line_filter_core regression: pass");
		else
			$display("tag_strip_escape_line_filter_core regression: fail");
		$finish;
	end

endmodule
